@@ src/esmv_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// esmv_pkg
// Shared types and field widths of the ELLPACK sparse matrix-vector unit.
// ---------------------------------------------------------------------------
package esmv_pkg;

   localparam int VAL_W   = 32;
   localparam int SUM_W   = 64;
   localparam int COL_W   = 20;
   localparam int VIDX_W  = 12;
   localparam int ROW_W   = 20;
   localparam int CNT_W   = 21;
   localparam int RWID_W  = 7;
   localparam int REQ_D_W = 96;
   localparam int RSP_D_W = 88;
   localparam int CSR_A_W = 4;
   localparam int CSR_D_W = 32;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_ENTRY = 1'b1;

   localparam logic [1:0] REG_COL_OFFSET = 2'd0;
   localparam logic [1:0] REG_ROW_WIDTH  = 2'd1;
   localparam logic [1:0] REG_ROW_COUNT  = 2'd2;

   typedef struct packed {
      logic             oob;
      logic             row_end;
      logic             last;
      logic [ROW_W-1:0] row_num;
   } tag_type;

endpackage

@@ src/esmv_vecmem.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// esmv_vecmem
// Vector store: one write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module esmv_vecmem #(
   parameter int DEPTH = 4096
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [$clog2(DEPTH)-1:0]          wr_addr,
   input  logic [esmv_pkg::VAL_W-1:0]        wr_data,
   input  logic                              rd_en,
   input  logic [$clog2(DEPTH)-1:0]          rd_addr,
   output logic [esmv_pkg::VAL_W-1:0]        rd_data
);
   import esmv_pkg::*;

   logic [VAL_W-1:0] mem [DEPTH];
   logic [VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/ell_sparse_matvec.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ell_sparse_matvec
// ELLPACK sparse matrix times dense vector with a saturating Q32.32 sum.
// ---------------------------------------------------------------------------
// Load words (tuser = 0) write Q16.16 vector elements into an on-chip vector
// memory; entry words (tuser = 1) stream padded row entries in row order, and
// after every row_width entries one result word carries the saturated row sum,
// the row number, a last-row flag on tlast and an index fault flag on tuser.
// One word is taken per clock cycle. An entry passes a three-stage pipeline
// (vector memory read, 32x32 multiply, saturating accumulate) and its row
// result is registered once the last entry of the row leaves accumulation.
// Input stalls only when a row result is ready while the previous result is
// still waiting in the output register.
module ell_sparse_matvec #(
   parameter int VEC_DEPTH     = 4096,
   parameter int MAX_ROW_WIDTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // vec_index[11:0], vec_value[43:12], entry_value[75:44], entry_column[95:76]
   input  logic [esmv_pkg::REQ_D_W-1:0]  req_tdata,
   // cmd[0]
   input  logic                          req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // row_sum[63:0], row_number[83:64], zero fill[87:84]
   output logic [esmv_pkg::RSP_D_W-1:0]  rsp_tdata,
   // index_fault[0]
   output logic                          rsp_tuser,
   output logic                          rsp_tlast,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [esmv_pkg::CSR_A_W-1:0]  csr_paddr,
   input  logic [esmv_pkg::CSR_D_W-1:0]  csr_pwdata,
   output logic [esmv_pkg::CSR_D_W-1:0]  csr_prdata,
   output logic                          csr_pready
);
   import esmv_pkg::*;

   localparam int AW = $clog2(VEC_DEPTH);
   localparam int CW = $clog2(MAX_ROW_WIDTH + 1);
   localparam int WW = (CW > RWID_W) ? CW : RWID_W;

   logic [COL_W-1:0]  col_offset_ff;
   logic [RWID_W-1:0] row_width_ff;
   logic [CNT_W-1:0]  row_count_ff;
   logic              csr_wr;

   logic [CW-1:0]     entry_cnt_ff, entry_cnt_in;
   logic [ROW_W-1:0]  row_cnt_ff, row_cnt_in;

   logic              adv;
   logic              accept;
   logic              cmd;
   logic [VIDX_W-1:0] vec_index;
   logic [VAL_W-1:0]  vec_value;
   logic [VAL_W-1:0]  entry_value;
   logic [COL_W-1:0]  entry_column;
   logic [COL_W-1:0]  idx;
   logic              oob;
   logic              load_ok;
   logic [WW-1:0]     width_eff, ent_next;
   logic [CNT_W-1:0]  count_eff, row_next;
   logic              row_end, last;
   tag_type           tag_in;

   logic              s1_valid_ff;
   tag_type           s1_tag_ff;
   logic [VAL_W-1:0]  s1_coef_ff;
   logic [VAL_W-1:0]  rd_data;
   logic signed [VAL_W-1:0] elem;
   logic signed [SUM_W-1:0] prod_in;

   logic              s2_valid_ff;
   tag_type           s2_tag_ff;
   logic [SUM_W-1:0]  s2_prod_ff;

   logic [SUM_W-1:0]  acc_ff, acc_in;
   logic              fault_ff, fault_in;
   logic [SUM_W-1:0]  sum_raw, sum_sat;
   logic              s2_fire_end;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]  rsp_sum_ff;
   logic [ROW_W-1:0]  rsp_row_ff;
   logic              rsp_last_ff;
   logic              rsp_fault_ff;

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      case (csr_paddr[3:2])
         REG_COL_OFFSET: csr_prdata = CSR_D_W'(col_offset_ff);
         REG_ROW_WIDTH:  csr_prdata = CSR_D_W'(row_width_ff);
         REG_ROW_COUNT:  csr_prdata = CSR_D_W'(row_count_ff);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_offset_ff <= '0;
         row_width_ff  <= RWID_W'(1);
         row_count_ff  <= CNT_W'(1);
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_COL_OFFSET: col_offset_ff <= csr_pwdata[COL_W-1:0];
            REG_ROW_WIDTH:  row_width_ff  <= csr_pwdata[RWID_W-1:0];
            REG_ROW_COUNT:  row_count_ff  <= csr_pwdata[CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Intake: address, range check and row bookkeeping
   assign adv        = !(s2_valid_ff && s2_tag_ff.row_end && rsp_valid_ff && !rsp_tready);
   assign req_tready = adv;
   assign accept     = req_tvalid && adv;

   assign cmd          = req_tuser;
   assign vec_index    = req_tdata[11:0];
   assign vec_value    = req_tdata[43:12];
   assign entry_value  = req_tdata[75:44];
   assign entry_column = req_tdata[95:76];

   assign idx     = (entry_column >= col_offset_ff) ? (entry_column - col_offset_ff) : '0;
   assign oob     = !(32'(idx) < VEC_DEPTH);
   assign load_ok = 32'(vec_index) < VEC_DEPTH;

   always_comb begin
      if (row_width_ff == '0) begin
         width_eff = WW'(1);
      end else if (WW'(row_width_ff) > WW'(MAX_ROW_WIDTH)) begin
         width_eff = WW'(MAX_ROW_WIDTH);
      end else begin
         width_eff = WW'(row_width_ff);
      end
      ent_next  = WW'(entry_cnt_ff) + WW'(1);
      row_end   = ent_next >= width_eff;
      count_eff = (row_count_ff == '0) ? CNT_W'(1) : row_count_ff;
      row_next  = CNT_W'(row_cnt_ff) + CNT_W'(1);
      last      = row_next >= count_eff;

      entry_cnt_in = row_end ? '0 : CW'(ent_next);
      if (row_end) begin
         row_cnt_in = last ? '0 : row_next[ROW_W-1:0];
      end else begin
         row_cnt_in = row_cnt_ff;
      end

      tag_in.oob     = oob;
      tag_in.row_end = row_end;
      tag_in.last    = last;
      tag_in.row_num = row_cnt_ff;
   end

   esmv_vecmem #(
      .DEPTH (VEC_DEPTH)
   ) u_vecmem (
      .clock   (clock),
      .wr_en   (accept && cmd == CMD_LOAD && load_ok),
      .wr_addr (AW'(vec_index)),
      .wr_data (vec_value),
      .rd_en   (accept && cmd == CMD_ENTRY),
      .rd_addr (AW'(idx)),
      .rd_data (rd_data)
   );

   // Multiply stage
   assign elem    = s1_tag_ff.oob ? '0 : $signed(rd_data);
   assign prod_in = $signed(s1_coef_ff) * elem;

   // Saturating accumulate stage
   always_comb begin
      sum_raw = acc_ff + s2_prod_ff;
      if (acc_ff[SUM_W-1] == s2_prod_ff[SUM_W-1] && sum_raw[SUM_W-1] != acc_ff[SUM_W-1]) begin
         sum_sat = acc_ff[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         sum_sat = sum_raw;
      end
      s2_fire_end = s2_valid_ff && s2_tag_ff.row_end && adv;
      acc_in   = acc_ff;
      fault_in = fault_ff;
      if (s2_valid_ff && adv) begin
         if (s2_tag_ff.row_end) begin
            acc_in   = '0;
            fault_in = 1'b0;
         end else begin
            acc_in   = sum_sat;
            fault_in = fault_ff | s2_tag_ff.oob;
         end
      end
      if (s2_fire_end) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_cnt_ff <= '0;
         row_cnt_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         acc_ff       <= '0;
         fault_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            s1_valid_ff <= accept && cmd == CMD_ENTRY;
            s2_valid_ff <= s1_valid_ff;
         end
         if (accept && cmd == CMD_ENTRY) begin
            entry_cnt_ff <= entry_cnt_in;
            row_cnt_ff   <= row_cnt_in;
         end
         acc_ff       <= acc_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_tag_ff  <= tag_in;
         s1_coef_ff <= entry_value;
         s2_tag_ff  <= s1_tag_ff;
         s2_prod_ff <= SUM_W'(prod_in);
      end
      if (s2_fire_end) begin
         rsp_sum_ff   <= sum_sat;
         rsp_row_ff   <= s2_tag_ff.row_num;
         rsp_last_ff  <= s2_tag_ff.last;
         rsp_fault_ff <= fault_ff | s2_tag_ff.oob;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_D_W - SUM_W - ROW_W)'(0), rsp_row_ff, rsp_sum_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_fault_ff;

   // Checks
   a_stall_needs_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled while the output register is free");

   a_fault_cleared: assert property (@(posedge clock) disable iff (reset)
      s2_fire_end |=> !fault_ff && acc_ff == '0)
      else $error("row state not cleared after a row result");

   a_entry_cnt_range: assert property (@(posedge clock) disable iff (reset)
      32'(entry_cnt_ff) < MAX_ROW_WIDTH)
      else $error("entry counter beyond the maximum row width");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      s2_fire_end |=> rsp_tvalid)
      else $error("row result not presented");

endmodule
